// ----- rtl/core/dnd24_pkg.sv -----
// Package for the 24-bit delayed-noise dither block.
// Holds register indexes, reset seeds, delay limits and the noise generator step.
// No dependencies.
package dnd24_pkg;

	// Register index taken from paddr[2]
	typedef enum logic {
		REG_DELAY = 1'b0,
		REG_PHASE = 1'b1
	} reg_idx_t;

	localparam int unsigned MAX_DELAY  = 2440;
	localparam int unsigned TAPS_W     = 12;
	localparam int unsigned SAMPLE_W   = 32;
	localparam logic [31:0] SEED_LEFT  = 32'd1;
	localparam logic [31:0] SEED_RIGHT = 32'd2;

	// One xorshift step, shifts 13, 17, 5
	function automatic logic [31:0] xorshift_next(input logic [31:0] s);
		logic [31:0] t;
		t = s ^ (s << 13);
		t = t ^ (t >> 17);
		t = t ^ (t << 5);
		return t;
	endfunction

endpackage

// ----- rtl/core/delayed_noise_dither_24bit.sv -----
// Stereo requantizer from Q1.31 to OUT_BITS-bit samples with delayed-noise dither.
// Uses dnd24_pkg for register indexes, seeds, delay limits and the generator step.
// The dither history lives in one synchronous ring memory, both channels per entry.
//
//  channel   dir   handshake                 payload
//  s_*       in    s_tvalid / s_tready       s_tdata: left_in, right_in (Q1.31)
//  m_*       out   m_tvalid / m_tready       m_tdata: left_out, right_out
//  apb       in    psel, penable, pready     pwdata/prdata: delay_taps, in_phase
//
// One word per cycle sustained unless m_tready stalls; path from accept to m_tvalid:
// ring read in the accept cycle, arithmetic and saturation into the output register.
// The ring is one read and one write per word, both at the accept edge; no clearing
// pass: a fill count marks history not yet written, which reads as zero.
// Reset: generators take seeds 1 and 2, pointer and fill count clear, delay 1, phase 0.
// A stall on m_tready holds both stages; s_tready drops only when both are full.
module delayed_noise_dither_24bit #(
	parameter int unsigned RING_DEPTH = 4096,
	parameter int unsigned OUT_BITS   = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [31:0] left_in, [63:32] right_in
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [((2*OUT_BITS+7)/8)*8-1:0] m_tdata, // left_out, right_out, zero pad
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned PTR_W = $clog2(RING_DEPTH);
	localparam int unsigned CW    = (PTR_W + 1 > dnd24_pkg::TAPS_W) ?
	                                PTR_W + 1 : dnd24_pkg::TAPS_W;
	localparam int unsigned SW    = dnd24_pkg::SAMPLE_W + OUT_BITS + 2;
	localparam int unsigned QW    = OUT_BITS + 2;
	localparam int unsigned TD_W  = ((2*OUT_BITS+7)/8)*8;
	localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);
	localparam logic [CW-1:0] MAXD_C  = CW'(dnd24_pkg::MAX_DELAY);
	localparam logic signed [QW-1:0] Q_HI = QW'((64'd1 << (OUT_BITS-1)) - 64'd1);
	localparam logic signed [QW-1:0] Q_LO = -QW'(64'd1 << (OUT_BITS-1));

	// Requantize one channel: floor(x*2^OB + g -/+ gd [-2^32] over 2^32), saturated
	function automatic logic [OUT_BITS-1:0] requant(
		input logic [31:0] x,
		input logic [31:0] g,
		input logic [31:0] gd,
		input logic        ph
	);
		logic signed [SW-1:0] s;
		logic signed [QW-1:0] q;
		logic [OUT_BITS-1:0]  r;
		s = $signed({{(SW-32){x[31]}}, x}) <<< OUT_BITS;
		s = s + $signed({{(SW-32){1'b0}}, g});
		if (ph) begin
			s = s + $signed({{(SW-32){1'b0}}, gd}) - $signed(SW'(64'd1 << 32));
		end else begin
			s = s - $signed({{(SW-32){1'b0}}, gd});
		end
		q = s[SW-1:32];
		if (q > Q_HI) begin
			r = Q_HI[OUT_BITS-1:0];
		end else if (q < Q_LO) begin
			r = Q_LO[OUT_BITS-1:0];
		end else begin
			r = q[OUT_BITS-1:0];
		end
		return r;
	endfunction

	// Configuration registers
	logic [dnd24_pkg::TAPS_W-1:0] delay_taps_q;
	logic                         in_phase_q;
	dnd24_pkg::reg_idx_t          reg_idx;

	assign reg_idx = dnd24_pkg::reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_taps_q <= dnd24_pkg::TAPS_W'(1);
			in_phase_q   <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				dnd24_pkg::REG_DELAY: delay_taps_q <= pwdata[dnd24_pkg::TAPS_W-1:0];
				dnd24_pkg::REG_PHASE: in_phase_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			dnd24_pkg::REG_DELAY: prdata = {{(32-dnd24_pkg::TAPS_W){1'b0}}, delay_taps_q};
			dnd24_pkg::REG_PHASE: prdata = {31'd0, in_phase_q};
			default:              prdata = 32'd0;
		endcase
	end

	// Effective delay: at least 1, at most MAX_DELAY and RING_DEPTH
	logic [CW-1:0] d_eff;
	always_comb begin
		d_eff = CW'(delay_taps_q);
		if (d_eff == '0) d_eff = CW'(1);
		if (d_eff > MAXD_C) d_eff = MAXD_C;
		if (d_eff > DEPTH_C) d_eff = DEPTH_C;
	end

	// Handshake and stage control
	logic vld_s1, out_vld_q;
	logic accept, adv_s1;

	assign adv_s1   = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv_s1;
	assign accept   = s_tvalid && s_tready;

	// Ring pointer, fill count and read address
	logic [PTR_W-1:0] ptr_q;
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    ptr_w;
	logic [CW-1:0]    rd_w;
	logic [PTR_W-1:0] rd_addr;
	logic             hist_ok;

	assign ptr_w   = CW'(ptr_q);
	assign rd_w    = (ptr_w >= d_eff) ? (ptr_w - d_eff) : (ptr_w + DEPTH_C - d_eff);
	assign rd_addr = rd_w[PTR_W-1:0];
	assign hist_ok = (fill_q >= d_eff);

	// Noise generators
	logic [31:0] gen_l_q, gen_r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			fill_q  <= '0;
			gen_l_q <= dnd24_pkg::SEED_LEFT;
			gen_r_q <= dnd24_pkg::SEED_RIGHT;
		end else if (accept) begin
			ptr_q   <= (ptr_w == DEPTH_C - CW'(1)) ? '0 : ptr_q + PTR_W'(1);
			if (fill_q != DEPTH_C) fill_q <= fill_q + CW'(1);
			gen_l_q <= dnd24_pkg::xorshift_next(gen_l_q);
			gen_r_q <= dnd24_pkg::xorshift_next(gen_r_q);
		end
	end

	// Dither ring: read before write at the accept edge, {right, left} per entry
	logic [63:0] ring_mem [RING_DEPTH];
	logic [63:0] ring_rd_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			ring_rd_s1     <= ring_mem[rd_addr];
			ring_mem[ptr_q] <= {gen_r_q, gen_l_q};
		end
	end

	// Stage 1 payload
	logic [31:0] x_l_s1, x_r_s1, g_l_s1, g_r_s1;
	logic        hist_ok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_l_s1     <= s_tdata[31:0];
			x_r_s1     <= s_tdata[63:32];
			g_l_s1     <= gen_l_q;
			g_r_s1     <= gen_r_q;
			hist_ok_s1 <= hist_ok;
		end
	end

	// Delayed dither, zero where history is not yet written
	logic [31:0] gd_l, gd_r;
	assign gd_l = hist_ok_s1 ? ring_rd_s1[31:0]  : 32'd0;
	assign gd_r = hist_ok_s1 ? ring_rd_s1[63:32] : 32'd0;

	// Output register
	logic [OUT_BITS-1:0] out_l_q, out_r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (!out_vld_q || m_tready) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_l_q <= requant(x_l_s1, g_l_s1, gd_l, in_phase_q);
			out_r_q <= requant(x_r_s1, g_r_s1, gd_r, in_phase_q);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = TD_W'({out_r_q, out_l_q});

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for delayed_noise_dither_24bit: stereo Q1.31 words in, dithered
// 24-bit words out, compared against an in-bench dither predictor kept in a small class.
// Depends on dnd24_pkg (register indexes, seeds, delay cap) and the block's RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned HIST_DEPTH = 4096;
	localparam int unsigned OUT_W      = 24;
	localparam int unsigned TAPS_W     = dnd24_pkg::TAPS_W;
	localparam int unsigned MAX_DELAY  = dnd24_pkg::MAX_DELAY;
	localparam longint      OUT_HI     = (longint'(1) <<< (OUT_W - 1)) - 1;
	localparam longint      OUT_LO     = -(longint'(1) <<< (OUT_W - 1));

	// output-side stall patterns
	typedef enum int {RX_OPEN, RX_MOSTLY_READY, RX_MOSTLY_STALLED, RX_TOGGLE} rx_pattern_t;

	// Dither predictor and store of expected output words
	class dither_book;
		logic [31:0]         gen_left, gen_right;
		logic [31:0]         hist_left[HIST_DEPTH];
		logic [31:0]         hist_right[HIST_DEPTH];
		logic [11:0]         wr_pos;
		logic [TAPS_W-1:0]   dly_reg;
		logic                add_mode;
		logic [2*OUT_W-1:0]  expected_q[$];
		int                  mismatches;
		int                  words_checked;
		int                  words_in;

		function new();
			gen_left = dnd24_pkg::SEED_LEFT;
			gen_right = dnd24_pkg::SEED_RIGHT;
			foreach (hist_left[i]) begin
				hist_left[i] = '0;
				hist_right[i] = '0;
			end
			wr_pos = '0;
			dly_reg = TAPS_W'(1);
			add_mode = 1'b0;
			mismatches = 0;
			words_checked = 0;
			words_in = 0;
		endfunction

		task report(string msg);
			if (mismatches < 30)
				$display("%0t mismatch: %s", $time, msg);
			mismatches++;
		endtask

		function void write_reg(dnd24_pkg::reg_idx_t idx, logic [31:0] value);
			case (idx)
				dnd24_pkg::REG_DELAY: dly_reg = value[TAPS_W-1:0];
				dnd24_pkg::REG_PHASE: add_mode = value[0];
			endcase
		endfunction

		function logic [31:0] read_reg(dnd24_pkg::reg_idx_t idx);
			return (idx == dnd24_pkg::REG_DELAY) ? 32'(dly_reg) : 32'(add_mode);
		endfunction

		// xorshift step, shifts 13 left, 17 right, 5 left
		function logic [31:0] noise_step(logic [31:0] s);
			logic [31:0] a, b;
			a = s ^ {s[18:0], 13'b0};
			b = a ^ {17'b0, a[31:17]};
			return b ^ {b[26:0], 5'b0};
		endfunction

		// sum in units of 2^-32 LSB, floor to an LSB, then saturate
		function logic [OUT_W-1:0] requant(logic [31:0] x, logic [31:0] g, logic [31:0] gd);
			longint acc;
			longint q;
			acc = longint'($signed(x)) * (longint'(1) <<< OUT_W);
			acc = acc + longint'(g);
			if (add_mode)
				acc = acc + longint'(gd) - (longint'(1) <<< 32);
			else
				acc = acc - longint'(gd);
			q = acc >>> 32;
			if (q > OUT_HI) q = OUT_HI;
			if (q < OUT_LO) q = OUT_LO;
			return q[OUT_W-1:0];
		endfunction

		// one accepted input word: predict, then log dither and advance generators
		function void note_input(logic [63:0] word);
			logic [11:0] d;
			logic [11:0] rd;
			d = dly_reg;
			if (d == 0) d = 12'd1;
			if (d > MAX_DELAY) d = 12'(MAX_DELAY);
			rd = wr_pos - d;
			expected_q.push_back({requant(word[63:32], gen_right, hist_right[rd]),
				requant(word[31:0], gen_left, hist_left[rd])});
			hist_left[wr_pos] = gen_left;
			hist_right[wr_pos] = gen_right;
			wr_pos = wr_pos + 12'd1;
			gen_left = noise_step(gen_left);
			gen_right = noise_step(gen_right);
			words_in++;
		endfunction

		task check_output(logic [2*OUT_W-1:0] word);
			logic [2*OUT_W-1:0] want;
			if (expected_q.size() == 0) begin
				report($sformatf("output word %h with nothing expected", word));
				return;
			end
			want = expected_q.pop_front();
			if (word[OUT_W-1:0] !== want[OUT_W-1:0])
				report($sformatf("word %0d left_out %h, expected %h",
					words_checked, word[OUT_W-1:0], want[OUT_W-1:0]));
			if (word[2*OUT_W-1:OUT_W] !== want[2*OUT_W-1:OUT_W])
				report($sformatf("word %0d right_out %h, expected %h",
					words_checked, word[2*OUT_W-1:OUT_W], want[2*OUT_W-1:OUT_W]));
			words_checked++;
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [63:0]       s_tdata = '0;   // [31:0] left_in, [63:32] right_in
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [2*OUT_W-1:0] m_tdata;       // [23:0] left_out, [47:24] right_out
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	dither_book   book = new();
	logic [63:0]  frame_q[$];
	int           settings_run = 0;
	rx_pattern_t  rx_mode = RX_OPEN;
	int           rx_left = 0;
	int           rx_tick = 0;

	delayed_noise_dither_24bit uut (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// output side: check the accepted word, then pick tready from the current pattern
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			book.check_output(m_tdata);
		if (rx_left == 0) begin
			rx_mode = rx_pattern_t'($urandom_range(0, 3));
			rx_left = $urandom_range(8, 120);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_OPEN:           m_tready <= 1'b1;
			RX_MOSTLY_READY:   m_tready <= ($urandom_range(0, 3) != 0);
			RX_MOSTLY_STALLED: m_tready <= ($urandom_range(0, 3) == 0);
			default:           m_tready <= rx_tick[1];
		endcase
	end

	// input side: send frame_q in bursts with random gaps between them
	task automatic play_frames();
		int burst_left;
		int gap_left;
		bit offered;
		burst_left = $urandom_range(1, 48);
		gap_left = 0;
		offered = s_tvalid;
		while (frame_q.size() > 0 || offered) begin
			@(posedge clk);
			if (s_tvalid && s_tready) begin
				book.note_input(s_tdata);
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
			// a word offered and not taken stays put
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
					offered = 1'b0;
				end else if (frame_q.size() > 0) begin
					s_tdata <= frame_q.pop_front();
					s_tvalid <= 1'b1;
					offered = 1'b1;
				end else begin
					s_tvalid <= 1'b0;
					offered = 1'b0;
				end
			end
		end
	endtask

	// wait for every expected word, then let the pipeline run empty
	task automatic drain();
		while (book.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one APB transfer: setup cycle, then access until pready
	task automatic apb_access(dnd24_pkg::reg_idx_t idx, logic write_en, logic [31:0] wdata,
			output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write_en;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_reg(dnd24_pkg::reg_idx_t idx);
		logic [31:0] back;
		apb_access(idx, 1'b0, $urandom, back);
		if (back !== book.read_reg(idx))
			book.report($sformatf("register %s reads %h, expected %h",
				idx.name(), back, book.read_reg(idx)));
	endtask

	task automatic set_reg(dnd24_pkg::reg_idx_t idx, logic [31:0] value);
		logic [31:0] unused;
		apb_access(idx, 1'b1, value, unused);
		book.write_reg(idx, value);
		check_reg(idx);
	endtask

	// full-scale ends, LSB boundaries and alternating bit patterns
	function automatic void push_corners();
		frame_q.push_back({32'h8000_0000, 32'h7FFF_FFFF});
		frame_q.push_back({32'h7FFF_FFFF, 32'h8000_0000});
		frame_q.push_back({32'hFFFF_FFFF, 32'h0000_0000});
		frame_q.push_back({32'hFFFF_FF00, 32'h0000_0100});
		frame_q.push_back({32'hFFFF_FF01, 32'h0000_00FF});
		frame_q.push_back({32'h8000_0100, 32'h7FFF_FF00});
		frame_q.push_back({32'hAAAA_AAAA, 32'h5555_5555});
		frame_q.push_back({32'h5555_5555, 32'hAAAA_AAAA});
	endfunction

	// uniform in two draws of five, else near either rail or around zero
	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 4))
			0:       return 32'h7FFF_FF00 | $urandom_range(0, 255);
			1:       return 32'h8000_0000 | $urandom_range(0, 255);
			2:       return $urandom_range(0, 4095) - 2048;
			default: return $urandom;
		endcase
	endfunction

	// one register setting: program it, stream words, let the block go idle
	task automatic run_setting(logic [TAPS_W-1:0] dly, logic phase, int n_random, bit corners);
		set_reg(dnd24_pkg::REG_DELAY, ($urandom & ~32'hFFF) | 32'(dly));
		set_reg(dnd24_pkg::REG_PHASE, ($urandom & ~32'h1) | 32'(phase));
		if (corners)
			push_corners();
		for (int i = 0; i < n_random; i++)
			frame_q.push_back({rand_sample(), rand_sample()});
		play_frames();
		drain();
		settings_run++;
	endtask

	initial begin
		logic [TAPS_W-1:0] dly;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset values, then corner words, the first of them while history still reads as zero
		check_reg(dnd24_pkg::REG_DELAY);
		check_reg(dnd24_pkg::REG_PHASE);
		push_corners();
		play_frames();
		drain();
		settings_run++;

		// delay below range, at the field maximum, and just above the cap
		run_setting('0, 1'b1, 0, 1'b1);
		run_setting('1, 1'b0, 0, 1'b1);
		run_setting(12'(MAX_DELAY + 1), 1'b1, 40, 1'b0);

		// random settings with random words
		for (int k = 0; k < 10; k++) begin
			case ($urandom_range(0, 5))
				0:       dly = TAPS_W'($urandom_range(1, 4));
				1:       dly = TAPS_W'($urandom_range(5, 64));
				2:       dly = TAPS_W'($urandom_range(65, MAX_DELAY));
				3:       dly = 12'(MAX_DELAY);
				4:       dly = TAPS_W'($urandom_range(MAX_DELAY + 1, 4095));
				default: dly = '0;
			endcase
			run_setting(dly, 1'($urandom_range(0, 1)), $urandom_range(40, 60), 1'b0);
		end

		// long run at the cap, then a short delay over the long history
		run_setting(12'(MAX_DELAY), 1'($urandom_range(0, 1)), 1400, 1'b0);
		run_setting(12'd1, 1'b1, 100, 1'b0);

		repeat (8) @(posedge clk);
		$display("checked %0d output words from %0d input words over %0d register settings",
			book.words_checked, book.words_in, settings_run);
		$display("covered: delays below, at and above the cap, both phase modes, long history");
		if (book.mismatches == 0) begin
			$display("delayed_noise_dither_24bit regression: pass");
		end else begin
			$display("delayed_noise_dither_24bit regression: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(2_000_000);
		$display("run timed out with %0d words outstanding", book.expected_q.size());
		$display("delayed_noise_dither_24bit regression: fail");
		$finish;
	end

endmodule
